// ===== sv/rj_pkg.sv =====
package rj_pkg;

    typedef logic signed [31:0] fix_t;

    // input transfer: state vector
    typedef struct packed {
        fix_t pos_x;
        fix_t pos_y;
        fix_t vel_x;
        fix_t vel_y;
    } in_t;

    // output transfer: Jacobian entries
    typedef struct packed {
        fix_t drange_dx;
        fix_t drange_dy;
        fix_t dbearing_dx;
        fix_t dbearing_dy;
        fix_t drate_dx;
        fix_t drate_dy;
        logic near_origin;
    } out_t;

    // front to back: classified item with squares and cross products
    typedef struct packed {
        logic [31:0]        xm;
        logic [31:0]        ym;
        logic               xn;
        logic               yn;
        logic               near;
        logic [63:0]        xx;
        logic [63:0]        yy;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
    } fq_t;

    localparam logic [15:0] THR_RESET   = 16'd66;
    localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG_MAG = 32'h8000_0000;
    localparam int          SQ_LAT      = 32;
    localparam int          DIV_STEPS   = 32;
    localparam int          DIV_LAT     = DIV_STEPS + 1;

endpackage

// ===== sv/radar_jacobian.sv =====
// Radar measurement Jacobian for a constant-velocity state.
// s_ channel: one transfer carries pos_x, pos_y, vel_x, vel_y (signed fixed
//   point, FRAC_BITS fraction bits). m_ channel: one transfer per input with
//   the six distinct Jacobian entries, saturated, plus near_origin.
// cfg_ channel: writes the 16-bit near-zero threshold; always ready. Write it
//   only while no item is in flight.
// Throughput: one item per cycle while m_ready is high. The path runs through
//   two front stages (classify, squares and cross products), the queue, a sum
//   stage, a 32-stage square root, two partial-product stages, 33-stage
//   dividers and the output register.
// Back pressure: while a result waits and m_ready is low, the back pipeline
//   holds; the two-entry queue and the front stages keep taking transfers
//   until they fill, then s_ready drops. No result is lost or repeated.
// Reset (aresetn low, synchronous): all in-flight items are dropped and the
//   threshold returns to 66 (about 0.001 at 16 fraction bits).
module radar_jacobian import rj_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0] thr_reg;
    fq_t         fq_in, fq_out;
    logic        fq_in_valid, fq_in_ready, fq_out_valid, fq_out_ready;

    assign cfg_ready = 1'b1;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // front: near-origin replacement, magnitudes, squares, cross products
    rj_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .thr     (thr_reg),
        .s_data  (s_data),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .q_data  (fq_in),
        .q_valid (fq_in_valid),
        .q_ready (fq_in_ready)
    );

    // decouples front from back so either may stall
    rj_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (fq_in),
        .in_valid  (fq_in_valid),
        .in_ready  (fq_in_ready),
        .out_data  (fq_out),
        .out_valid (fq_out_valid),
        .out_ready (fq_out_ready)
    );

    // back: root, r^3, six pipelined dividers, saturation
    rj_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_data  (fq_out),
        .q_valid (fq_out_valid),
        .q_ready (fq_out_ready),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

endmodule

// ===== sv/rj_front.sv =====
module rj_front import rj_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] thr,
    input  in_t         s_data,
    input  logic        s_valid,
    output logic        s_ready,
    output fq_t         q_data,
    output logic        q_valid,
    input  logic        q_ready
);

    logic               f1_valid_reg, f2_valid_reg;
    logic               f1_adv, f2_adv;
    logic [31:0]        ax, ay, thr_w;
    logic               near;
    logic [31:0]        xm1_reg, ym1_reg;
    logic               xn1_reg, yn1_reg, near1_reg;
    fix_t               px1_reg, py1_reg, vx1_reg, vy1_reg;
    fq_t                f2_reg;

    assign f2_adv  = !f2_valid_reg || q_ready;
    assign f1_adv  = !f1_valid_reg || f2_adv;
    assign s_ready = f1_adv;

    // magnitudes; the most negative value maps to 2^31
    assign ax    = s_data.pos_x[31] ? (~s_data.pos_x + 32'd1) : s_data.pos_x;
    assign ay    = s_data.pos_y[31] ? (~s_data.pos_y + 32'd1) : s_data.pos_y;
    assign thr_w = {16'd0, thr};
    assign near  = (ax < thr_w) && (ay < thr_w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else begin
            if (f1_adv) begin
                f1_valid_reg <= s_valid;
            end
            if (f2_adv) begin
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (f1_adv) begin
            xm1_reg   <= near ? thr_w : ax;
            ym1_reg   <= near ? thr_w : ay;
            xn1_reg   <= near ? 1'b0 : s_data.pos_x[31];
            yn1_reg   <= near ? 1'b0 : s_data.pos_y[31];
            near1_reg <= near;
            px1_reg   <= near ? fix_t'(thr_w) : s_data.pos_x;
            py1_reg   <= near ? fix_t'(thr_w) : s_data.pos_y;
            vx1_reg   <= s_data.vel_x;
            vy1_reg   <= s_data.vel_y;
        end
        if (f2_adv) begin
            f2_reg.xm   <= xm1_reg;
            f2_reg.ym   <= ym1_reg;
            f2_reg.xn   <= xn1_reg;
            f2_reg.yn   <= yn1_reg;
            f2_reg.near <= near1_reg;
            f2_reg.xx   <= xm1_reg * xm1_reg;
            f2_reg.yy   <= ym1_reg * ym1_reg;
            f2_reg.p1   <= vx1_reg * py1_reg;
            f2_reg.p2   <= vy1_reg * px1_reg;
        end
    end

    assign q_data  = f2_reg;
    assign q_valid = f2_valid_reg;

endmodule

// ===== sv/rj_queue.sv =====
module rj_queue import rj_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  fq_t  in_data,
    input  logic in_valid,
    output logic in_ready,
    output fq_t  out_data,
    output logic out_valid,
    input  logic out_ready
);

    fq_t        mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== sv/rj_sqrt.sv =====
module rj_sqrt import rj_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] v,
    output logic [31:0] root
);

    // one result bit per stage, digit-by-digit, rounded down
    logic [33:0] rem_reg  [SQ_LAT];
    logic [31:0] root_reg [SQ_LAT];
    logic [63:0] v_reg    [SQ_LAT];

    genvar i;
    generate
        for (i = 0; i < SQ_LAT; i++) begin : g_step
            logic [33:0] rem_in;
            logic [31:0] root_in;
            logic [63:0] v_in;
            logic [35:0] cur, trial;
            logic        ge;

            if (i == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign v_in    = v;
            end else begin : g_next
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
                assign v_in    = v_reg[i-1];
            end

            assign cur   = {rem_in, v_in[63-2*i -: 2]};
            assign trial = {2'b00, root_in, 2'b01};
            assign ge    = (cur >= trial);

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i]  <= ge ? 34'(cur - trial) : cur[33:0];
                    root_reg[i] <= {root_in[30:0], ge};
                    v_reg[i]    <= v_in;
                end
            end
        end
    endgenerate

    assign root = root_reg[SQ_LAT-1];

endmodule

// ===== sv/rj_div.sv =====
module rj_div import rj_pkg::*; #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [NW-1:0]     num,
    input  logic [DW-1:0]     den,
    output logic [DIV_STEPS-1:0] q,
    output logic              big
);

    localparam int HW = NW - DIV_STEPS;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [CW-1:0]        hi_c, den_c;
    logic [DW-1:0]        rem_reg [DIV_STEPS];
    logic [DW-1:0]        den_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] lo_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS+1];
    logic                 big_reg [DIV_STEPS+1];

    // quotient overflows 32 bits exactly when the top part is not below den
    assign hi_c  = CW'(num[NW-1:DIV_STEPS]);
    assign den_c = CW'(den);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= hi_c[DW-1:0];
            den_reg[0] <= den;
            lo_reg[0]  <= num[DIV_STEPS-1:0];
            q_reg[0]   <= '0;
            big_reg[0] <= (hi_c >= den_c);
        end
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            logic [DW:0] trial;
            logic        ge;

            assign trial = {rem_reg[k], lo_reg[k][DIV_STEPS-1]};
            assign ge    = (trial >= {1'b0, den_reg[k]});

            always_ff @(posedge aclk) begin
                if (en) begin
                    q_reg[k+1]   <= {q_reg[k][DIV_STEPS-2:0], ge};
                    big_reg[k+1] <= big_reg[k];
                end
            end

            if (k < DIV_STEPS - 1) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[k+1] <= ge ? DW'(trial - {1'b0, den_reg[k]})
                                           : trial[DW-1:0];
                        den_reg[k+1] <= den_reg[k];
                        lo_reg[k+1]  <= {lo_reg[k][DIV_STEPS-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign q   = q_reg[DIV_STEPS];
    assign big = big_reg[DIV_STEPS];

endmodule

// ===== sv/rj_back.sv =====
module rj_back import rj_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  fq_t  q_data,
    input  logic q_valid,
    output logic q_ready,
    output out_t m_data,
    output logic m_valid,
    input  logic m_ready
);

    typedef struct packed {
        logic [31:0] xm;
        logic [31:0] ym;
        logic        xn;
        logic        yn;
        logic        cn;
        logic        near;
        logic        zero;
        logic [63:0] cm;
        logic [63:0] s;
    } sd_t;

    typedef struct packed {
        logic xn;
        logic yn;
        logic cn;
        logic near;
        logic zero;
    } fl_t;

    logic        en;
    logic        m_valid_reg;
    out_t        m_data_reg;
    logic [64:0] dsum;
    logic        b0_valid_reg;
    sd_t         b0_reg;
    sd_t         sq_reg  [SQ_LAT];
    logic        sqv_reg [SQ_LAT];
    logic [31:0] root;

    logic        m1_valid_reg, m2_valid_reg;
    sd_t         m1_reg, m2_reg;
    logic [31:0] r1_reg, r2_reg;
    logic [63:0] sr_lo_reg, sr_hi_reg, yc_lo_reg, yc_hi_reg, xc_lo_reg, xc_hi_reg;
    logic [95:0] s3_reg, yc_reg, xc_reg;

    fl_t         fl_reg [DIV_LAT];
    logic        dv_reg [DIV_LAT];

    logic [31:0] q0, q1, q2, q3, q4, q5;
    logic        g0, g1, g2, g3, g4, g5;

    function automatic logic [31:0] sat(input logic [31:0] qv, input logic big,
                                        input logic neg);
        logic [31:0] mag;
        if (neg) begin
            mag = (big || qv > SAT_NEG_MAG) ? SAT_NEG_MAG : qv;
            return 32'd0 - mag;
        end
        return (big || qv > SAT_POS) ? SAT_POS : qv;
    endfunction

    // whole pipeline advances while the output register can move
    assign en      = !m_valid_reg || m_ready;
    assign q_ready = en;

    assign dsum = {q_data.p1[63], q_data.p1} - {q_data.p2[63], q_data.p2};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int j = 0; j < SQ_LAT; j++) begin
                sqv_reg[j] <= 1'b0;
            end
            for (int j = 0; j < DIV_LAT; j++) begin
                dv_reg[j] <= 1'b0;
            end
        end else if (en) begin
            b0_valid_reg <= q_valid;
            sqv_reg[0]   <= b0_valid_reg;
            for (int j = 1; j < SQ_LAT; j++) begin
                sqv_reg[j] <= sqv_reg[j-1];
            end
            m1_valid_reg <= sqv_reg[SQ_LAT-1];
            m2_valid_reg <= m1_valid_reg;
            dv_reg[0]    <= m2_valid_reg;
            for (int j = 1; j < DIV_LAT; j++) begin
                dv_reg[j] <= dv_reg[j-1];
            end
            m_valid_reg  <= dv_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b0_reg.xm   <= q_data.xm;
            b0_reg.ym   <= q_data.ym;
            b0_reg.xn   <= q_data.xn;
            b0_reg.yn   <= q_data.yn;
            b0_reg.near <= q_data.near;
            b0_reg.s    <= q_data.xx + q_data.yy;
            b0_reg.zero <= (q_data.xx == 64'd0) && (q_data.yy == 64'd0);
            b0_reg.cn   <= dsum[64];
            b0_reg.cm   <= dsum[64] ? 64'(~dsum + 65'd1) : dsum[63:0];

            sq_reg[0] <= b0_reg;
            for (int j = 1; j < SQ_LAT; j++) begin
                sq_reg[j] <= sq_reg[j-1];
            end

            // split wide products into 32x32 partials
            m1_reg    <= sq_reg[SQ_LAT-1];
            r1_reg    <= root;
            sr_lo_reg <= sq_reg[SQ_LAT-1].s[31:0] * root;
            sr_hi_reg <= sq_reg[SQ_LAT-1].s[63:32] * root;
            yc_lo_reg <= sq_reg[SQ_LAT-1].cm[31:0] * sq_reg[SQ_LAT-1].ym;
            yc_hi_reg <= sq_reg[SQ_LAT-1].cm[63:32] * sq_reg[SQ_LAT-1].ym;
            xc_lo_reg <= sq_reg[SQ_LAT-1].cm[31:0] * sq_reg[SQ_LAT-1].xm;
            xc_hi_reg <= sq_reg[SQ_LAT-1].cm[63:32] * sq_reg[SQ_LAT-1].xm;

            m2_reg <= m1_reg;
            r2_reg <= r1_reg;
            s3_reg <= {32'd0, sr_lo_reg} + {sr_hi_reg, 32'd0};
            yc_reg <= {32'd0, yc_lo_reg} + {yc_hi_reg, 32'd0};
            xc_reg <= {32'd0, xc_lo_reg} + {xc_hi_reg, 32'd0};

            fl_reg[0] <= '{xn: m2_reg.xn, yn: m2_reg.yn, cn: m2_reg.cn,
                           near: m2_reg.near, zero: m2_reg.zero};
            for (int j = 1; j < DIV_LAT; j++) begin
                fl_reg[j] <= fl_reg[j-1];
            end

            m_data_reg.near_origin <= fl_reg[DIV_LAT-1].near;
            if (fl_reg[DIV_LAT-1].zero) begin
                m_data_reg.drange_dx   <= '0;
                m_data_reg.drange_dy   <= '0;
                m_data_reg.dbearing_dx <= '0;
                m_data_reg.dbearing_dy <= '0;
                m_data_reg.drate_dx    <= '0;
                m_data_reg.drate_dy    <= '0;
            end else begin
                m_data_reg.drange_dx   <= fix_t'(sat(q0, g0, fl_reg[DIV_LAT-1].xn));
                m_data_reg.drange_dy   <= fix_t'(sat(q1, g1, fl_reg[DIV_LAT-1].yn));
                m_data_reg.dbearing_dx <= fix_t'(sat(q2, g2, !fl_reg[DIV_LAT-1].yn));
                m_data_reg.dbearing_dy <= fix_t'(sat(q3, g3, fl_reg[DIV_LAT-1].xn));
                m_data_reg.drate_dx    <= fix_t'(sat(q4, g4,
                    fl_reg[DIV_LAT-1].yn != fl_reg[DIV_LAT-1].cn));
                m_data_reg.drate_dy    <= fix_t'(sat(q5, g5,
                    fl_reg[DIV_LAT-1].xn == fl_reg[DIV_LAT-1].cn));
            end
        end
    end

    rj_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .v    (b0_reg.s),
        .root (root)
    );

    rj_div #(.NW(32 + FRAC_BITS), .DW(32)) u_div0 (
        .aclk(aclk), .en(en), .num({m2_reg.xm, {FRAC_BITS{1'b0}}}),
        .den(r2_reg), .q(q0), .big(g0)
    );
    rj_div #(.NW(32 + FRAC_BITS), .DW(32)) u_div1 (
        .aclk(aclk), .en(en), .num({m2_reg.ym, {FRAC_BITS{1'b0}}}),
        .den(r2_reg), .q(q1), .big(g1)
    );
    rj_div #(.NW(32 + 2*FRAC_BITS), .DW(64)) u_div2 (
        .aclk(aclk), .en(en), .num({m2_reg.ym, {(2*FRAC_BITS){1'b0}}}),
        .den(m2_reg.s), .q(q2), .big(g2)
    );
    rj_div #(.NW(32 + 2*FRAC_BITS), .DW(64)) u_div3 (
        .aclk(aclk), .en(en), .num({m2_reg.xm, {(2*FRAC_BITS){1'b0}}}),
        .den(m2_reg.s), .q(q3), .big(g3)
    );
    rj_div #(.NW(96 + FRAC_BITS), .DW(96)) u_div4 (
        .aclk(aclk), .en(en), .num({yc_reg, {FRAC_BITS{1'b0}}}),
        .den(s3_reg), .q(q4), .big(g4)
    );
    rj_div #(.NW(96 + FRAC_BITS), .DW(96)) u_div5 (
        .aclk(aclk), .en(en), .num({xc_reg, {FRAC_BITS{1'b0}}}),
        .den(s3_reg), .q(q5), .big(g5)
    );

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

endmodule
